### hdl/pulse_width_nibble_receiver_assert.svh
// assertion macros shared by the receiver checks
`ifndef PULSE_WIDTH_NIBBLE_RECEIVER_ASSERT_SVH
`define PULSE_WIDTH_NIBBLE_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PWNR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pwnr check failed");

// next-cycle implication, disabled while reset is low
`define PWNR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pwnr check failed");

`endif

### hdl/pwnr_pkg.sv
package pwnr_pkg;

    localparam int MAX_NIBBLES = 32;
    localparam int CNT_W       = $clog2(MAX_NIBBLES + 1);
    localparam int TICK_W      = 8;
    localparam int NIB_W       = 4;
    localparam int KIND_W      = 2;
    localparam int PKT_W       = 6;
    localparam int CFG_IDX_W   = 3;

    typedef logic [TICK_W-1:0] t_ticks;
    typedef logic [NIB_W-1:0]  t_nibble;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [PKT_W-1:0]  t_pkt_count;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_PULSE,
        PH_GAP
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_NIBBLE  = 2'd0,
        KIND_PARTIAL = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ZERO = 3'd0,
        CFG_MAX_ZERO = 3'd1,
        CFG_MIN_ONE  = 3'd2,
        CFG_MAX_ONE  = 3'd3,
        CFG_TIMEOUT  = 3'd4
    } t_cfg_idx;

    localparam t_ticks RST_MIN_ZERO = 8'd11;
    localparam t_ticks RST_MAX_ZERO = 8'd23;
    localparam t_ticks RST_MIN_ONE  = 8'd49;
    localparam t_ticks RST_MAX_ONE  = 8'd61;
    localparam t_ticks RST_TIMEOUT  = 8'd112;

    typedef struct packed {
        t_ticks min_zero;
        t_ticks max_zero;
        t_ticks min_one;
        t_ticks max_one;
        t_ticks timeout;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        t_nibble    value;
        logic       bad;
        t_pkt_count nibbles;
        t_nibble    first;
        t_nibble    calc;
        logic       ok;
    } t_result;

endpackage

### hdl/pwnr_if.sv
// line sample channel
interface pwnr_sample_if;
    logic valid;
    logic ready;
    logic line_low;

    modport source (output valid, output line_low, input ready);
    modport sink (input valid, input line_low, output ready);
endinterface

// result channel
interface pwnr_result_if;
    logic                       valid;
    logic                       ready;
    logic [pwnr_pkg::KIND_W-1:0] result_kind;
    pwnr_pkg::t_nibble          nibble_value;
    logic                       nibble_bad;
    pwnr_pkg::t_pkt_count       packet_nibbles;
    pwnr_pkg::t_nibble          first_nibble;
    pwnr_pkg::t_nibble          checksum_calc;
    logic                       checksum_ok;

    modport source (output valid, output result_kind, output nibble_value,
                    output nibble_bad, output packet_nibbles, output first_nibble,
                    output checksum_calc, output checksum_ok, input ready);
    modport sink (input valid, input result_kind, input nibble_value,
                  input nibble_bad, input packet_nibbles, input first_nibble,
                  input checksum_calc, input checksum_ok, output ready);
endinterface

// configuration write channel
interface pwnr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pwnr_pkg::CFG_IDX_W-1:0] index;
    pwnr_pkg::t_ticks              data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/pwnr_cfg.sv
module pwnr_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pwnr_cfg_if.sink       i_cfg,
    output pwnr_pkg::t_cfg o_cfg
);
    import pwnr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_MIN_ZERO: n_cfg.min_zero = i_cfg.data;
                CFG_MAX_ZERO: n_cfg.max_zero = i_cfg.data;
                CFG_MIN_ONE:  n_cfg.min_one  = i_cfg.data;
                CFG_MAX_ONE:  n_cfg.max_one  = i_cfg.data;
                CFG_TIMEOUT:  n_cfg.timeout  = i_cfg.data;
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_zero <= RST_MIN_ZERO;
            r_cfg.max_zero <= RST_MAX_ZERO;
            r_cfg.min_one  <= RST_MIN_ONE;
            r_cfg.max_one  <= RST_MAX_ONE;
            r_cfg.timeout  <= RST_TIMEOUT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### hdl/pwnr_core.sv
module pwnr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_line,
    input  pwnr_pkg::t_cfg    i_cfg,
    output logic              o_res_vld,
    output pwnr_pkg::t_result o_res
);
    import pwnr_pkg::*;

    t_phase  r_phase, n_phase;
    logic    r_prev, n_prev;
    t_ticks  r_elapsed, n_elapsed;
    logic [1:0] r_bit_phase, n_bit_phase;
    t_nibble r_shift, n_shift;
    logic    r_nib_err, n_nib_err;
    t_count  r_total, n_total;
    t_nibble r_xor, n_xor;
    t_nibble r_last, n_last;
    t_nibble r_first, n_first;
    logic    r_pkt_err, n_pkt_err;

    always_comb begin
        logic    rise;
        logic    fall;
        logic    bit_v;
        logic    bad_v;
        t_nibble calc;

        rise = i_line & ~r_prev;
        fall = ~i_line & r_prev;
        bit_v = 1'b0;
        bad_v = 1'b0;
        calc  = t_nibble'((r_xor ^ r_last) + 1'b1);

        n_phase     = r_phase;
        n_prev      = i_line;
        n_elapsed   = r_elapsed;
        n_bit_phase = r_bit_phase;
        n_shift     = r_shift;
        n_nib_err   = r_nib_err;
        n_total     = r_total;
        n_xor       = r_xor;
        n_last      = r_last;
        n_first     = r_first;
        n_pkt_err   = r_pkt_err;
        o_res_vld   = 1'b0;
        o_res       = '0;
        o_res.kind  = KIND_NIBBLE;

        // tick count and packet timeout
        if (r_phase != PH_WAIT) begin
            if (r_elapsed != '1) begin
                n_elapsed = r_elapsed + 1'b1;
            end
            if (n_elapsed >= i_cfg.timeout) begin
                if (r_bit_phase != '0) begin
                    o_res_vld   = 1'b1;
                    o_res.kind  = KIND_PARTIAL;
                    o_res.value = r_shift;
                    o_res.bad   = r_nib_err;
                end else if (r_total > t_count'(2)) begin
                    o_res_vld     = 1'b1;
                    o_res.kind    = KIND_END;
                    o_res.value   = r_last;
                    o_res.bad     = r_pkt_err;
                    o_res.nibbles = t_pkt_count'(r_total);
                    o_res.first   = r_first;
                    o_res.calc    = calc;
                    o_res.ok      = (calc == r_last) && !r_pkt_err;
                end
                n_bit_phase = '0;
                n_shift     = '0;
                n_nib_err   = 1'b0;
                n_total     = '0;
                n_xor       = '0;
                n_last      = '0;
                n_first     = '0;
                n_pkt_err   = 1'b0;
                n_phase     = PH_WAIT;
            end
        end

        if (rise && (n_phase == PH_WAIT || n_phase == PH_GAP)) begin
            if (n_phase == PH_WAIT) begin
                n_bit_phase = '0;
                n_shift     = '0;
                n_nib_err   = 1'b0;
                n_total     = '0;
                n_xor       = '0;
                n_last      = '0;
                n_first     = '0;
                n_pkt_err   = 1'b0;
            end
            n_phase   = PH_PULSE;
            n_elapsed = '0;
        end else if (fall && n_phase == PH_PULSE) begin
            // windows tested in order, first match wins
            if (n_elapsed < i_cfg.min_zero) begin
                bad_v = 1'b1;
            end else if (n_elapsed <= i_cfg.max_zero) begin
                bit_v = 1'b0;
            end else if (n_elapsed < i_cfg.min_one) begin
                bad_v = 1'b1;
            end else if (n_elapsed <= i_cfg.max_one) begin
                bit_v = 1'b1;
            end else begin
                bad_v = 1'b1;
            end

            n_phase     = PH_GAP;
            n_shift     = {n_shift[NIB_W-2:0], bit_v};
            n_nib_err   = n_nib_err | bad_v;
            n_bit_phase = n_bit_phase + 1'b1;
            if (n_bit_phase == '0) begin
                o_res_vld   = 1'b1;
                o_res.kind  = KIND_NIBBLE;
                o_res.value = n_shift;
                o_res.bad   = n_nib_err;
                if (n_total == '0) begin
                    n_first = n_shift;
                end
                if (n_total < t_count'(MAX_NIBBLES)) begin
                    n_total = n_total + 1'b1;
                end
                n_xor     = n_xor ^ n_shift;
                n_last    = n_shift;
                n_pkt_err = n_pkt_err | n_nib_err;
                n_shift   = '0;
                n_nib_err = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_prev      <= 1'b0;
            r_elapsed   <= '0;
            r_bit_phase <= '0;
            r_shift     <= '0;
            r_nib_err   <= 1'b0;
            r_total     <= '0;
            r_xor       <= '0;
            r_last      <= '0;
            r_first     <= '0;
            r_pkt_err   <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_prev      <= n_prev;
            r_elapsed   <= n_elapsed;
            r_bit_phase <= n_bit_phase;
            r_shift     <= n_shift;
            r_nib_err   <= n_nib_err;
            r_total     <= n_total;
            r_xor       <= n_xor;
            r_last      <= n_last;
            r_first     <= n_first;
            r_pkt_err   <= n_pkt_err;
        end
    end

endmodule

### hdl/pulse_width_nibble_receiver.sv
// channel    dir  handshake      payload
// i_sample   in   valid/ready    line_low
// o_result   out  valid/ready    result_kind, nibble_value, nibble_bad, packet_nibbles,
//                                first_nibble, checksum_calc, checksum_ok
// i_cfg      in   valid/ready    index, data (always ready)
//
// one line sample is taken every cycle while i_sample.ready is high
// the sample register feeds the decode logic, whose result lands in the output register
// the decode stage advances on a held sample whenever the output register is empty or being drained
// a stalled output holds the sample register, and i_sample.ready drops only then
// reset is synchronous and active low, and loads the default pulse windows
module pulse_width_nibble_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pwnr_sample_if.sink i_sample,
    pwnr_cfg_if.sink    i_cfg,
    pwnr_result_if.source o_result
);
    import pwnr_pkg::*;

    // sample register
    logic    r_in_vld;
    logic    r_in_line;

    // output register
    logic    r_out_vld;
    t_result r_out;

    t_cfg    cfg;
    logic    fire;
    logic    res_vld;
    t_result res;

    // decode one sample when the result slot can take whatever it produces
    assign fire           = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_sample.ready = !r_in_vld || fire;

    pwnr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pwnr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_line    (r_in_line),
        .i_cfg     (cfg),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    // sample capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_vld <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in_line <= i_sample.line_low;
        end
    end

    // result slot: refilled on decode, emptied on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= res_vld;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_vld) begin
            r_out <= res;
        end
    end

    assign o_result.valid          = r_out_vld;
    assign o_result.result_kind    = r_out.kind;
    assign o_result.nibble_value   = r_out.value;
    assign o_result.nibble_bad     = r_out.bad;
    assign o_result.packet_nibbles = r_out.nibbles;
    assign o_result.first_nibble   = r_out.first;
    assign o_result.checksum_calc  = r_out.calc;
    assign o_result.checksum_ok    = r_out.ok;

endmodule

### hdl/pwnr_checker.sv
`include "pulse_width_nibble_receiver_assert.svh"

module pwnr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [pwnr_pkg::KIND_W-1:0] i_kind,
    input pwnr_pkg::t_nibble          i_value,
    input logic                       i_bad,
    input pwnr_pkg::t_pkt_count       i_nibbles,
    input pwnr_pkg::t_nibble          i_first,
    input pwnr_pkg::t_nibble          i_calc,
    input logic                       i_ok
);
    import pwnr_pkg::*;

    // packet summary fields are only filled on a packet end
    `PWNR_ASSERT_IMP(a_summary_zero, i_clk, i_rst_n,
        i_out_valid && i_kind != KIND_END,
        i_nibbles == '0 && i_first == '0 && i_calc == '0 && !i_ok)

    // a packet end needs more than two nibbles
    `PWNR_ASSERT_IMP(a_end_count, i_clk, i_rst_n,
        i_out_valid && i_kind == KIND_END, i_nibbles > t_pkt_count'(2))

    // a good checksum means a matching last nibble and no bad nibble
    `PWNR_ASSERT_IMP(a_ok_consistent, i_clk, i_rst_n,
        i_out_valid && i_kind == KIND_END && i_ok,
        i_calc == i_value && !i_bad)

    // a stalled result holds
    `PWNR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready,
        i_out_valid && $stable({i_kind, i_value, i_bad, i_nibbles, i_first, i_calc, i_ok}))

endmodule

bind pulse_width_nibble_receiver pwnr_checker u_pwnr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_kind      (o_result.result_kind),
    .i_value     (o_result.nibble_value),
    .i_bad       (o_result.nibble_bad),
    .i_nibbles   (o_result.packet_nibbles),
    .i_first     (o_result.first_nibble),
    .i_calc      (o_result.checksum_calc),
    .i_ok        (o_result.checksum_ok)
);
